// ===== src/qprs_pkg.sv =====
// ----------------------------------------------------------------------------
// qprs_pkg
// shared defaults for the quadratic positive root solver
// ----------------------------------------------------------------------------
package qprs_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned COEF_BITS_DEF = 32;

endpackage

// ===== src/qprs_if.sv =====
// ----------------------------------------------------------------------------
// qprs_if
// valid/ready channels carrying coefficient items and root items
// ----------------------------------------------------------------------------
interface qprs_in_if
  import qprs_pkg::*;
#(
  parameter int unsigned CW = COEF_BITS_DEF
) ();
  logic                 valid;
  logic                 ready;
  logic                 kind;
  logic signed [CW-1:0] coef_a;
  logic signed [CW-1:0] coef_b;
  logic signed [CW-1:0] coef_c;

  modport source (output valid, kind, coef_a, coef_b, coef_c, input ready);
  modport sink   (input valid, kind, coef_a, coef_b, coef_c, output ready);
endinterface

interface qprs_out_if
  import qprs_pkg::*;
#(
  parameter int unsigned CW = COEF_BITS_DEF
) ();
  logic          valid;
  logic          ready;
  logic [CW-2:0] root;
  logic          no_root;
  logic          saturated;

  modport source (output valid, root, no_root, saturated, input ready);
  modport sink   (input valid, root, no_root, saturated, output ready);
endinterface

// ===== src/quadratic_positive_root_solver.sv =====
// ----------------------------------------------------------------------------
// quadratic_positive_root_solver
// pipelined fixed point solver for one non-negative root of a*x^2+b*x+c=0
// ----------------------------------------------------------------------------
// channel  | dir | handshake           | payload
// coef_i   | in  | valid/ready         | kind, coef_a, coef_b, coef_c
// root_o   | out | valid/ready         | root, no_root, saturated
//
// pipe order: stages 0 and 1, the discriminant register, the one-bit-pair-per-stage
//   square root, the numerator register, the one-bit-per-stage restoring divider
//   and the output register
// throughput: one item per cycle while the output is taken
// stall: the whole pipe holds when the output register is full and not taken
// reset: clears all valid bits, payload registers are not reset
module quadratic_positive_root_solver
  import qprs_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned COEF_BITS = COEF_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qprs_in_if.sink    coef_i,
  qprs_out_if.source root_o
);

  localparam int unsigned CW  = COEF_BITS;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned DW  = 2*CW + 2;      // discriminant magnitude
  localparam int unsigned RW  = DW + 2*F;      // radicand, even
  localparam int unsigned SQW = RW / 2;        // square root bits
  localparam int unsigned RMW = SQW + 3;       // square root remainder
  localparam int unsigned NW  = CW + F + 2;    // numerator magnitude
  localparam int unsigned DVW = CW + 1;        // divisor 2|a|
  localparam int unsigned DRW = CW + 2;        // divider remainder

  // global advance: the pipe moves when the output slot is free or taken
  logic adv;
  logic out_valid_q;

  assign adv          = !out_valid_q || root_o.ready;
  assign coef_i.ready = adv;

  // --------------------------------------------------------------------------
  // stage 0: magnitudes and signs
  // --------------------------------------------------------------------------
  logic [CW-1:0] a_u, b_u, c_u;
  logic          v0_q, kind0_q, an0_q, bn0_q, cn0_q;
  logic [CW-1:0] am0_q, bm0_q, cm0_q;

  assign a_u = coef_i.coef_a;
  assign b_u = coef_i.coef_b;
  assign c_u = coef_i.coef_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (adv) begin
      v0_q <= coef_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind0_q <= coef_i.kind;
      an0_q   <= a_u[CW-1];
      bn0_q   <= b_u[CW-1];
      cn0_q   <= c_u[CW-1];
      am0_q   <= a_u[CW-1] ? (~a_u + 1'b1) : a_u;
      bm0_q   <= b_u[CW-1] ? (~b_u + 1'b1) : b_u;
      cm0_q   <= c_u[CW-1] ? (~c_u + 1'b1) : c_u;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: b*b and a*c
  // --------------------------------------------------------------------------
  logic            v1_q, kind1_q, an1_q, bn1_q, acn1_q;
  logic [CW-1:0]   am1_q, bm1_q;
  logic [2*CW-1:0] b2_1_q, ac1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      kind1_q <= kind0_q;
      an1_q   <= an0_q;
      bn1_q   <= bn0_q;
      acn1_q  <= an0_q ^ cn0_q;
      am1_q   <= am0_q;
      bm1_q   <= bm0_q;
      b2_1_q  <= bm0_q * bm0_q;
      ac1_q   <= am0_q * cm0_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: discriminant, exact
  // --------------------------------------------------------------------------
  logic [DW-1:0] b2_w, ac4_w, d_sum, d_dif;
  logic          d_neg;

  assign b2_w  = {2'b00, b2_1_q};
  assign ac4_w = {ac1_q, 2'b00};
  assign d_sum = b2_w + ac4_w;
  assign d_dif = b2_w - ac4_w;
  assign d_neg = !acn1_q && (ac4_w > b2_w);

  // square root pipe registers, index k holds the input of stage k
  logic [RW-1:0]  sq_x_q    [SQW+1];
  logic [RMW-1:0] sq_rem_q  [SQW+1];
  logic [SQW-1:0] sq_res_q  [SQW+1];
  logic           sq_v_q    [SQW+1];
  logic           sq_kind_q [SQW+1];
  logic           sq_an_q   [SQW+1];
  logic           sq_bn_q   [SQW+1];
  logic           sq_bad_q  [SQW+1];
  logic [CW-1:0]  sq_am_q   [SQW+1];
  logic [CW-1:0]  sq_bm_q   [SQW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (adv) begin
      sq_v_q[0] <= v1_q;
    end
  end

  // zero a or negative discriminant: no root
  always_ff @(posedge clk_i) begin
    if (adv) begin
      sq_x_q[0]    <= {(acn1_q ? d_sum : d_dif), {(2*F){1'b0}}};
      sq_rem_q[0]  <= '0;
      sq_res_q[0]  <= '0;
      sq_kind_q[0] <= kind1_q;
      sq_an_q[0]   <= an1_q;
      sq_bn_q[0]   <= bn1_q;
      sq_bad_q[0]  <= d_neg || (am1_q == '0);
      sq_am_q[0]   <= am1_q;
      sq_bm_q[0]   <= bm1_q;
    end
  end

  // --------------------------------------------------------------------------
  // square root: one result bit per stage, radicand shifts out two bits
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < SQW; k++) begin : g_sqrt
    logic [RMW-1:0] rs, trial, rem_n;
    logic           ge;

    assign rs    = {sq_rem_q[k][RMW-3:0], sq_x_q[k][RW-1:RW-2]};
    assign trial = {1'b0, sq_res_q[k], 2'b01};
    assign ge    = rs >= trial;
    assign rem_n = ge ? (rs - trial) : rs;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k+1] <= sq_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_x_q[k+1]    <= {sq_x_q[k][RW-3:0], 2'b00};
        sq_rem_q[k+1]  <= rem_n;
        sq_res_q[k+1]  <= {sq_res_q[k][SQW-2:0], ge};
        sq_kind_q[k+1] <= sq_kind_q[k];
        sq_an_q[k+1]   <= sq_an_q[k];
        sq_bn_q[k+1]   <= sq_bn_q[k];
        sq_bad_q[k+1]  <= sq_bad_q[k];
        sq_am_q[k+1]   <= sq_am_q[k];
        sq_bm_q[k+1]   <= sq_bm_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // numerator stage: -b*2^F +/- sqrt, root choice
  // --------------------------------------------------------------------------
  logic [NW-1:0] s_w, b_w, n_sum, n_sb, n_bs;
  logic          s_ge_b, an_s, bn_s;
  logic [NW-1:0] np_mag, nm_mag, pick_mag;
  logic          np_neg, nm_neg, np_ok, nm_ok, pick_ok;

  assign an_s   = sq_an_q[SQW];
  assign bn_s   = sq_bn_q[SQW];
  assign s_w    = NW'(sq_res_q[SQW]);
  assign b_w    = NW'({sq_bm_q[SQW], {F{1'b0}}});
  assign n_sum  = s_w + b_w;
  assign n_sb   = s_w - b_w;
  assign n_bs   = b_w - s_w;
  assign s_ge_b = s_w >= b_w;

  always_comb begin
    if (bn_s) begin
      np_mag = n_sum;
      np_neg = 1'b0;
      nm_mag = s_ge_b ? n_sb : n_bs;
      nm_neg = s_ge_b;
    end else begin
      np_mag = s_ge_b ? n_sb : n_bs;
      np_neg = !s_ge_b;
      nm_mag = n_sum;
      nm_neg = 1'b1;
    end
    // a root is usable when it is zero or its numerator has the sign of a
    np_ok = (np_mag == '0) || (np_neg == an_s);
    nm_ok = (nm_mag == '0) || (nm_neg == an_s);
    pick_ok  = 1'b0;
    pick_mag = np_mag;
    if (!sq_kind_q[SQW]) begin
      pick_ok  = np_ok;
      pick_mag = np_mag;
    end else if (an_s) begin
      // a negative: plus root is the smaller one
      pick_ok  = np_ok || nm_ok;
      pick_mag = np_ok ? np_mag : nm_mag;
    end else begin
      pick_ok  = nm_ok || np_ok;
      pick_mag = nm_ok ? nm_mag : np_mag;
    end
  end

  // divider pipe registers
  logic [NW-1:0]  dv_n_q   [NW+1];
  logic [DRW-2:0] dv_rem_q [NW+1];
  logic [NW-1:0]  dv_q_q   [NW+1];
  logic [DVW-1:0] dv_den_q [NW+1];
  logic           dv_bad_q [NW+1];
  logic           dv_v_q   [NW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (adv) begin
      dv_v_q[0] <= sq_v_q[SQW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dv_n_q[0]   <= pick_mag;
      dv_rem_q[0] <= '0;
      dv_q_q[0]   <= '0;
      dv_den_q[0] <= {sq_am_q[SQW], 1'b0};
      dv_bad_q[0] <= sq_bad_q[SQW] || !pick_ok;
    end
  end

  // --------------------------------------------------------------------------
  // restoring divider: one quotient bit per stage
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DRW-1:0] rs, dn, rem_n;
    logic           ge;

    assign rs    = {dv_rem_q[k], dv_n_q[k][NW-1]};
    assign dn    = {1'b0, dv_den_q[k]};
    assign ge    = rs >= dn;
    assign rem_n = ge ? (rs - dn) : rs;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v_q[k+1] <= dv_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_n_q[k+1]   <= {dv_n_q[k][NW-2:0], 1'b0};
        dv_rem_q[k+1] <= rem_n[DRW-2:0];
        dv_q_q[k+1]   <= {dv_q_q[k][NW-2:0], ge};
        dv_den_q[k+1] <= dv_den_q[k];
        dv_bad_q[k+1] <= dv_bad_q[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // output register: saturation and no-root cleanup
  // --------------------------------------------------------------------------
  logic [NW-1:0] quo;
  logic          too_big, nr;
  logic [CW-2:0] root_q;
  logic          no_root_q, sat_q;

  assign quo     = dv_q_q[NW];
  assign nr      = dv_bad_q[NW];
  assign too_big = quo[NW-1:CW-1] != '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= dv_v_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      no_root_q <= nr;
      sat_q     <= !nr && too_big;
      if (nr) begin
        root_q <= '0;
      end else if (too_big) begin
        root_q <= '1;
      end else begin
        root_q <= quo[CW-2:0];
      end
    end
  end

  assign root_o.valid     = out_valid_q;
  assign root_o.root      = root_q;
  assign root_o.no_root   = no_root_q;
  assign root_o.saturated = sat_q;

endmodule

// ===== src/qprs_checker.sv =====
// ----------------------------------------------------------------------------
// qprs_checker
// port level checks of the quadratic positive root solver
// ----------------------------------------------------------------------------
module qprs_checker
  import qprs_pkg::*;
#(
  parameter int unsigned CW = COEF_BITS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [CW-2:0] root,
  input logic          no_root,
  input logic          saturated
);

  // a held result stays offered
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // no root carries a zero root and no saturation
  a_norooot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && no_root |-> root == '0 && !saturated)
    else $error("no-root item with payload");

  // saturation shows the largest code
  a_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && saturated |-> root == '1)
    else $error("saturated item without full-scale root");

  // the input side only waits on a full, untaken output
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow the output slot");

endmodule

bind quadratic_positive_root_solver qprs_checker #(.CW(COEF_BITS)) u_qprs_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (coef_i.ready),
  .out_valid (root_o.valid),
  .out_ready (root_o.ready),
  .root      (root_o.root),
  .no_root   (root_o.no_root),
  .saturated (root_o.saturated)
);
